// ===== src/gru_pkg.sv =====
// Shared constants for the Givens rotation unit: default widths and operation codes.
// No dependencies.
`timescale 1ns / 1ps
package gru_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 30;
   localparam logic FUNC_GENERATE = 1'b0;
   localparam logic FUNC_APPLY    = 1'b1;
endpackage

// ===== src/gru_if.sv =====
// Request and response channel interfaces of the Givens rotation unit.
// Depends on gru_pkg for default widths.
`timescale 1ns / 1ps
interface gru_req_if #(parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] first_value;
   logic signed [DATA_WIDTH-1:0] second_value;
   logic signed [DATA_WIDTH-1:0] cos_value;
   logic signed [DATA_WIDTH-1:0] sin_value;
   modport source (output valid, func, first_value, second_value, cos_value, sin_value,
                   input ready);
   modport sink   (input valid, func, first_value, second_value, cos_value, sin_value,
                   output ready);
endinterface

interface gru_rsp_if #(parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF);
   logic                       valid;
   logic                       ready;
   logic signed [DATA_WIDTH:0] first_out;
   logic signed [DATA_WIDTH:0] second_out;
   logic                       saturated;
   modport source (output valid, first_out, second_out, saturated, input ready);
   modport sink   (input valid, first_out, second_out, saturated, output ready);
endinterface

// ===== src/gru_ratio_step.sv =====
// One bit of the exact ratio search: largest w with w*w*sum <= rhs.
// Keeps w*w*sum and w*sum incrementally so a step is shifts, adds and one compare.
`timescale 1ns / 1ps
module gru_ratio_step #(
   parameter int ACC_WIDTH  = 132,
   parameter int ROOT_WIDTH = 32,
   parameter int BIT_POS    = 0
) (
   input  logic [ACC_WIDTH-1:0]  sum,
   input  logic [ACC_WIDTH-1:0]  rhs,
   input  logic [ACC_WIDTH-1:0]  acc_in,
   input  logic [ACC_WIDTH-1:0]  lin_in,
   input  logic [ROOT_WIDTH-1:0] root_in,
   output logic [ACC_WIDTH-1:0]  acc_out,
   output logic [ACC_WIDTH-1:0]  lin_out,
   output logic [ROOT_WIDTH-1:0] root_out
);
   logic [ACC_WIDTH-1:0] cand;
   logic                 take;

   // (w + 2^b)^2 s = w^2 s + 2^(b+1) w s + 2^(2b) s
   assign cand = acc_in + (lin_in << (BIT_POS + 1)) + (sum << (2 * BIT_POS));
   assign take = (cand <= rhs);

   assign acc_out  = take ? cand : acc_in;
   assign lin_out  = take ? (lin_in + (sum << BIT_POS)) : lin_in;
   assign root_out = root_in | (ROOT_WIDTH'(take) << BIT_POS);
endmodule

// ===== src/givens_rotation_unit.sv =====
// Givens rotation unit top level: operand stages, apply datapath and the ratio pipeline.
// Depends on gru_pkg, gru_if (gru_req_if, gru_rsp_if) and gru_ratio_step.
`timescale 1ns / 1ps
// Takes one word per clock unless the pipeline is stalled, and returns one word per request,
// in order. func = generate turns (x, y) into cosine and sine in Q(W-F).F, each magnitude
// exactly round(m*2^F/r) with r = sqrt(x^2 + y^2); y = 0 gives (1.0, 0). func = apply
// returns (c*x + s*y, c*y - s*x) rounded back to the scale of x and y and clipped to W+1
// bits, with saturated set if either side clipped. Both operations pass through the same
// stages: three operand/multiply/sum stages, one setup stage, FRAC_BITS + 2 ratio stages
// that each settle one result bit, and the output register. Throughput is one word per
// cycle while the output is taken; every stage holds its word when the next one is full
// and cannot move on, so empty stages keep accepting while a result waits at the output.
module givens_rotation_unit #(
   parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = gru_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   gru_req_if.sink    req_chan,
   gru_rsp_if.source  rsp_chan
);
   localparam int W     = DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int NSTEP = F + 2;             // ratio bits, MSB first
   localparam int AW    = 2 * W + 2 * F + 4; // w^2 * sum headroom
   localparam int PW    = 2 * W;             // product width
   localparam int NT    = NSTEP + 5;         // total stages incl. output
   localparam int OUTI  = NT - 1;

   // ---- stage handshake: a stage loads when empty or when it moves on ----
   logic [NT-1:0] vld_ff, vld_in;
   logic [NT:0]   adv;

   always_comb begin
      adv[NT] = rsp_chan.ready;
      for (int i = NT - 1; i >= 0; i--) begin
         adv[i] = ~vld_ff[i] | adv[i+1];
      end
      vld_in[0] = adv[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < NT; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = adv[0];

   // ---- stage 0: operand capture ----
   logic                s0_func_ff;
   logic signed [W-1:0] s0_x_ff, s0_y_ff, s0_c_ff, s0_s_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_func_ff <= req_chan.func;
         s0_x_ff    <= req_chan.first_value;
         s0_y_ff    <= req_chan.second_value;
         s0_c_ff    <= req_chan.cos_value;
         s0_s_ff    <= req_chan.sin_value;
      end
   end

   // ---- stage 1: products, magnitudes and signs ----
   logic [W-1:0]         ax, ay;
   logic                 s1_func_ff, s1_yz_ff, s1_cneg_ff, s1_sneg_ff;
   logic signed [PW-1:0] s1_sqx_ff, s1_sqy_ff, s1_cx_ff, s1_sy_ff, s1_cy_ff, s1_sx_ff;

   assign ax = s0_x_ff[W-1] ? W'(-s0_x_ff) : W'(s0_x_ff);
   assign ay = s0_y_ff[W-1] ? W'(-s0_y_ff) : W'(s0_y_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_func_ff <= s0_func_ff;
         s1_yz_ff   <= (ay == '0);
         // the larger side's output stays positive (x's on a tie); the other carries sign(x)*sign(y)
         s1_cneg_ff <= (ay > ax) & (s0_x_ff[W-1] ^ s0_y_ff[W-1]);
         s1_sneg_ff <= (ay <= ax) & (s0_x_ff[W-1] ^ s0_y_ff[W-1]);
         s1_sqx_ff  <= s0_x_ff * s0_x_ff;
         s1_sqy_ff  <= s0_y_ff * s0_y_ff;
         s1_cx_ff   <= s0_c_ff * s0_x_ff;
         s1_sy_ff   <= s0_s_ff * s0_y_ff;
         s1_cy_ff   <= s0_c_ff * s0_y_ff;
         s1_sx_ff   <= s0_s_ff * s0_x_ff;
      end
   end

   // ---- stage 2: sum of squares, ratio targets, rounded apply sums ----
   localparam logic signed [PW:0] HALF = (PW+1)'(1) << (F - 1);

   logic signed [PW:0] psum, qsum;
   logic               s2_func_ff, s2_yz_ff, s2_cneg_ff, s2_sneg_ff;
   logic [AW-1:0]      s2_sum_ff, s2_rc_ff, s2_rs_ff;
   logic signed [PW:0] s2_p_ff, s2_q_ff;

   assign psum = (PW+1)'(s1_cx_ff) + (PW+1)'(s1_sy_ff) + HALF;
   assign qsum = (PW+1)'(s1_cy_ff) - (PW+1)'(s1_sx_ff) + HALF;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_func_ff <= s1_func_ff;
         s2_yz_ff   <= s1_yz_ff;
         s2_cneg_ff <= s1_cneg_ff;
         s2_sneg_ff <= s1_sneg_ff;
         s2_sum_ff  <= AW'($unsigned(s1_sqx_ff)) + AW'($unsigned(s1_sqy_ff));
         s2_rc_ff   <= AW'($unsigned(s1_sqx_ff)) << (2 * F + 2);
         s2_rs_ff   <= AW'($unsigned(s1_sqy_ff)) << (2 * F + 2);
         s2_p_ff    <= psum >>> F;
         s2_q_ff    <= qsum >>> F;
      end
   end

   // ---- ratio pipeline: index 0 is the setup stage, k+1 follows step k ----
   logic                func_ff [0:NSTEP];
   logic                yz_ff   [0:NSTEP];
   logic                cneg_ff [0:NSTEP];
   logic                sneg_ff [0:NSTEP];
   logic                sat_ff  [0:NSTEP];
   logic signed [W:0]   p_ff    [0:NSTEP];
   logic signed [W:0]   q_ff    [0:NSTEP];
   logic [AW-1:0]       sum_ff  [0:NSTEP];
   logic [AW-1:0]       rc_ff   [0:NSTEP];
   logic [AW-1:0]       rs_ff   [0:NSTEP];
   logic [AW-1:0]       ac_ff   [0:NSTEP];
   logic [AW-1:0]       as_ff   [0:NSTEP];
   logic [AW-1:0]       bc_ff   [0:NSTEP];
   logic [AW-1:0]       bs_ff   [0:NSTEP];
   logic [NSTEP-1:0]    wc_ff   [0:NSTEP];
   logic [NSTEP-1:0]    ws_ff   [0:NSTEP];

   // clip to W+1 bits: fits when bits W and up all equal the sign
   logic p_fit, q_fit;
   assign p_fit = (s2_p_ff[PW:W] == '0) || (s2_p_ff[PW:W] == '1);
   assign q_fit = (s2_q_ff[PW:W] == '0) || (s2_q_ff[PW:W] == '1);

   localparam logic signed [W:0] OUT_MAX = {1'b0, {W{1'b1}}};
   localparam logic signed [W:0] OUT_MIN = {1'b1, {W{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         func_ff[0] <= s2_func_ff;
         yz_ff[0]   <= s2_yz_ff;
         cneg_ff[0] <= s2_cneg_ff;
         sneg_ff[0] <= s2_sneg_ff;
         sat_ff[0]  <= ~p_fit | ~q_fit;
         p_ff[0]    <= p_fit ? s2_p_ff[W:0] : (s2_p_ff[PW] ? OUT_MIN : OUT_MAX);
         q_ff[0]    <= q_fit ? s2_q_ff[W:0] : (s2_q_ff[PW] ? OUT_MIN : OUT_MAX);
         sum_ff[0]  <= s2_sum_ff;
         rc_ff[0]   <= s2_rc_ff;
         rs_ff[0]   <= s2_rs_ff;
         ac_ff[0]   <= '0;
         as_ff[0]   <= '0;
         bc_ff[0]   <= '0;
         bs_ff[0]   <= '0;
         wc_ff[0]   <= '0;
         ws_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      logic [AW-1:0]    ac_nx, as_nx, bc_nx, bs_nx;
      logic [NSTEP-1:0] wc_nx, ws_nx;

      gru_ratio_step #(.ACC_WIDTH(AW), .ROOT_WIDTH(NSTEP), .BIT_POS(NSTEP - 1 - k)) u_cos (
         .sum(sum_ff[k]), .rhs(rc_ff[k]), .acc_in(ac_ff[k]), .lin_in(bc_ff[k]),
         .root_in(wc_ff[k]), .acc_out(ac_nx), .lin_out(bc_nx), .root_out(wc_nx)
      );
      gru_ratio_step #(.ACC_WIDTH(AW), .ROOT_WIDTH(NSTEP), .BIT_POS(NSTEP - 1 - k)) u_sin (
         .sum(sum_ff[k]), .rhs(rs_ff[k]), .acc_in(as_ff[k]), .lin_in(bs_ff[k]),
         .root_in(ws_ff[k]), .acc_out(as_nx), .lin_out(bs_nx), .root_out(ws_nx)
      );

      always_ff @(posedge clock) begin
         if (adv[4+k]) begin
            func_ff[k+1] <= func_ff[k];
            yz_ff[k+1]   <= yz_ff[k];
            cneg_ff[k+1] <= cneg_ff[k];
            sneg_ff[k+1] <= sneg_ff[k];
            sat_ff[k+1]  <= sat_ff[k];
            p_ff[k+1]    <= p_ff[k];
            q_ff[k+1]    <= q_ff[k];
            sum_ff[k+1]  <= sum_ff[k];
            rc_ff[k+1]   <= rc_ff[k];
            rs_ff[k+1]   <= rs_ff[k];
            ac_ff[k+1]   <= ac_nx;
            as_ff[k+1]   <= as_nx;
            bc_ff[k+1]   <= bc_nx;
            bs_ff[k+1]   <= bs_nx;
            wc_ff[k+1]   <= wc_nx;
            ws_ff[k+1]   <= ws_nx;
         end
      end
   end

   // ---- output register: round the ratio (w+1)>>1, apply sign, or pass the apply result ----
   logic [NSTEP:0]     cm_wide, sm_wide;
   logic signed [W:0]  cmag, smag, gen_c, gen_s;
   logic               out_func_ff;
   logic signed [W:0]  out_first_ff, out_second_ff;
   logic               out_sat_ff;

   localparam logic signed [W:0] ONE = (W+1)'(1) << F;

   assign cm_wide = ({1'b0, wc_ff[NSTEP]} + (NSTEP+1)'(1)) >> 1;
   assign sm_wide = ({1'b0, ws_ff[NSTEP]} + (NSTEP+1)'(1)) >> 1;
   assign cmag    = (W+1)'(cm_wide);
   assign smag    = (W+1)'(sm_wide);
   assign gen_c   = yz_ff[NSTEP] ? ONE : (cneg_ff[NSTEP] ? -cmag : cmag);
   assign gen_s   = yz_ff[NSTEP] ? '0  : (sneg_ff[NSTEP] ? -smag : smag);

   always_ff @(posedge clock) begin
      if (adv[OUTI]) begin
         out_func_ff <= func_ff[NSTEP];
         if (func_ff[NSTEP] == gru_pkg::FUNC_APPLY) begin
            out_first_ff  <= p_ff[NSTEP];
            out_second_ff <= q_ff[NSTEP];
            out_sat_ff    <= sat_ff[NSTEP];
         end else begin
            out_first_ff  <= gen_c;
            out_second_ff <= gen_s;
            out_sat_ff    <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid      = vld_ff[OUTI];
   assign rsp_chan.first_out  = out_first_ff;
   assign rsp_chan.second_out = out_second_ff;
   assign rsp_chan.saturated  = out_sat_ff;

   // ---- checks ----
   // a result waiting at the output is never dropped by the stage behind it
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[OUTI] && !rsp_chan.ready |=> vld_ff[OUTI])
      else $error("output word lost while stalled");

   // an accepted request always lands in the capture stage
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted request not captured");

   // generated cosine and sine stay within unit magnitude and never flag saturation
   a_gen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && out_func_ff == gru_pkg::FUNC_GENERATE |->
         !rsp_chan.saturated && rsp_chan.first_out <= ONE && rsp_chan.first_out >= -ONE
         && rsp_chan.second_out <= ONE && rsp_chan.second_out >= -ONE)
      else $error("generated rotation out of range");
endmodule
